### design/cacs_pkg.sv
`default_nettype none

package cacs_pkg;

  // field widths of one input item
  localparam int unsigned CPU_W  = 6;
  localparam int unsigned LAT_W  = 16;
  localparam int unsigned UTIL_W = 11;
  localparam int unsigned CAP_W  = 11;

  // derived widths
  localparam int unsigned SUM_W   = UTIL_W + 1;          // util plus task util
  localparam int unsigned CAP_SH  = 10;                  // x1024 capacity scale
  localparam int unsigned REL_W   = SUM_W + CAP_SH;      // relative utilization
  localparam int unsigned BLAT_W  = LAT_W + 1;           // wake latency widened by a carry bit
  localparam int unsigned DIV_STEPS = REL_W;             // one quotient bit a step
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [REL_W-1:0]  REL_SENTINEL = '1;
  localparam logic [BLAT_W-1:0] LAT_SENTINEL = '1;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_UTIL_EST = 1'b0;   // register index, paddr[2]

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 8;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_CAND   = 2'd1,
    CMD_FINISH = 2'd2
  } command_t;

  // input beat payload, last member in the lowest bits
  typedef struct packed {
    logic              pad;
    logic              sync;
    logic [UTIL_W-1:0] task_load;
    logic              is_task_cpu;
    logic              is_current;
    logic              shares_cache;
    logic [CAP_W-1:0]  cpu_capacity;
    logic [UTIL_W-1:0] cpu_util_est;
    logic [UTIL_W-1:0] cpu_util;
    logic [LAT_W-1:0]  wake_lat;
    logic              cpu_idle;
    logic [CPU_W-1:0]  cpu_id;
  } item_t;

  // controller to datapath
  typedef struct packed {
    logic start;      // open a request, seed the best candidate
    logic fast;       // previous processor idle, answer at once
    logic finish;     // load the winner into the result register
    logic cand_load;  // latch candidate, set up the divider
    logic div_step;   // one quotient bit
    logic update;     // compare against best and keep the winner
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic skip;       // candidate out of range or beaten by an idle winner
  } dp_sts_t;

endpackage

`default_nettype wire

### design/capacity_aware_cpu_select.sv
// results: a finish, and a start whose previous processor is idle, give their result in the cycle after acceptance
// a scored candidate beat goes through a load, the divider steps and a compare
// one beat at a time; a scored candidate holds the input for the radix-2 divider (one quotient bit a cycle)
// start, finish and skipped candidates are taken back to back while the result register has room
// reset: synchronous active-low rst_n, clears the search and sets util_est_enable
`default_nettype none

module capacity_aware_cpu_select
  import cacs_pkg::*;
#(
  parameter int unsigned NUM_CPUS = 64
)
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // cpu_id[5:0], cpu_idle[6], wake_lat[22:7], cpu_util[33:23],
  // cpu_util_est[44:34], cpu_capacity[55:45], shares_cache[56], is_current[57],
  // is_task_cpu[58], task_load[69:59], sync[70], zero[71]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // command[1:0]
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // selected_cpu[5:0], zero[7:6]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // fast_path[0]
  output logic                       out_tuser,
  // configuration port
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  item_t            item;
  command_t         in_command;
  dp_cmd_t          dp_cmd;
  dp_sts_t          dp_sts;
  logic             util_est_en_r;
  logic [CPU_W-1:0] sel_cpu;
  logic             sel_fast;
  logic             cfg_wr;

  assign item       = item_t'(in_tdata);
  assign in_command = command_t'(in_tuser);

  // register file: only util_est_enable, at byte address 0
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_UTIL_EST) ?
                      {{(CFG_DATA_W-1){1'b0}}, util_est_en_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      util_est_en_r <= 1'b1;
    end else if (cfg_wr && cfg_paddr[2] == REG_UTIL_EST) begin
      util_est_en_r <= cfg_pwdata[0];
    end
  end

  // sequencer: accepts beats, runs the divider, flags results
  cacs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_command (in_command),
    .in_idle    (item.cpu_idle),
    .in_ready   (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .sts        (dp_sts),
    .cmd        (dp_cmd)
  );

  // scoring, divider, tie-break and result register
  cacs_dp #(
    .NUM_CPUS (NUM_CPUS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .item     (item),
    .est_en   (util_est_en_r),
    .cmd      (dp_cmd),
    .sts      (dp_sts),
    .sel_cpu  (sel_cpu),
    .sel_fast (sel_fast)
  );

  assign out_tdata = {(OUT_DATA_W - CPU_W)'(0), sel_cpu};
  assign out_tuser = sel_fast;

  // a beat is only taken when the result register can hold a new result
  a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!out_tvalid || out_tready))
    else $error("input taken while result register is blocked");

  // a scored candidate keeps the input closed while the divider runs
  a_cand_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_command == CMD_CAND && !dp_sts.skip)
      |=> !in_tready)
    else $error("input reopened during candidate scoring");

  // an idle previous processor is answered on the next cycle via the fast path
  a_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_command == CMD_START && item.cpu_idle)
      |=> (out_tvalid && out_tuser && out_tdata[CPU_W-1:0] == $past(item.cpu_id)))
    else $error("fast-path result missing");

  // a finish always produces a slow-path result
  a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_command == CMD_FINISH) |=> (out_tvalid && !out_tuser))
    else $error("finish result missing");

endmodule

`default_nettype wire

### design/cacs_ctrl.sv
`default_nettype none

module cacs_ctrl
  import cacs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire command_t in_command,
  input  wire logic     in_idle,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_sts_t  sts,
  output dp_cmd_t       cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_CMP
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 accept;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_START: begin
              cmd.start = 1'b1;
              if (in_idle) begin
                cmd.fast      = 1'b1;
                out_valid_nxt = 1'b1;
              end
            end
            CMD_CAND: begin
              if (!sts.skip) begin
                cmd.cand_load = 1'b1;
                cnt_nxt       = '0;
                state_nxt     = S_DIV;
              end
            end
            CMD_FINISH: begin
              cmd.finish    = 1'b1;
              out_valid_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.update = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### design/cacs_dp.sv
`default_nettype none

module cacs_dp
  import cacs_pkg::*;
#(
  parameter int unsigned NUM_CPUS = 64
)
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire item_t   item,
  input  wire logic    est_en,
  input  wire dp_cmd_t cmd,
  output dp_sts_t      sts,
  output logic [CPU_W-1:0] sel_cpu,
  output logic         sel_fast
);

  // request and best-so-far state
  logic [CPU_W-1:0]  req_prev_cpu_r;
  logic [UTIL_W-1:0] req_task_util_r;
  logic              req_sync_r;
  logic [UTIL_W-1:0] req_running_util_r;
  logic [CPU_W-1:0]  best_cpu_r;
  logic [REL_W-1:0]  best_rel_r;
  logic [CAP_W-1:0]  best_cap_r;
  logic [BLAT_W-1:0] best_lat_r;
  logic              best_cache_r;
  logic              best_cur_r;
  logic              found_idle_r;

  // latched candidate and divider
  logic [CPU_W-1:0]  cand_cpu_r;
  logic [CAP_W-1:0]  cand_cap_r;
  logic [BLAT_W-1:0] cand_lat_r;
  logic              cand_cache_r;
  logic              cand_cur_r;
  logic              cand_idle_r;
  logic [REL_W-1:0]  dvd_r;    // dividend in, quotient out
  logic [CAP_W-1:0]  rem_r;

  logic [CPU_W-1:0]  sel_cpu_r;
  logic              sel_fast_r;

  logic              cur_sync;
  logic              cand_idle;
  logic              in_range;
  logic [UTIL_W-1:0] u_base;
  logic [UTIL_W-1:0] u_max;
  logic [SUM_W-1:0]  u_sum;
  logic [CAP_W-1:0]  cap_fix;
  logic [BLAT_W-1:0] lat_in;
  logic [CAP_W:0]    trial;
  logic              q_bit;
  logic              beats;

  assign cur_sync  = req_sync_r && item.is_current;
  assign cand_idle = cur_sync || item.cpu_idle;
  assign in_range  = {1'b0, item.cpu_id} < (CPU_W + 1)'(NUM_CPUS);
  assign sts.skip  = !in_range || (found_idle_r && !cand_idle);

  // utilization of the candidate with the task placed on it
  always_comb begin
    u_base = item.cpu_util;
    if (cur_sync) begin
      u_base = (item.cpu_util > req_running_util_r) ?
               item.cpu_util - req_running_util_r : '0;
    end
    u_max = (est_en && item.cpu_util_est > u_base) ? item.cpu_util_est : u_base;
    u_sum = {1'b0, u_max} + (item.is_task_cpu ? '0 : {1'b0, req_task_util_r});
  end

  assign cap_fix = (item.cpu_capacity == '0) ? CAP_W'(1) : item.cpu_capacity;
  assign lat_in  = cand_idle ? BLAT_W'(item.wake_lat) + BLAT_W'(1) : '0;

  // restoring divider step
  assign trial = {rem_r, dvd_r[REL_W-1]};
  assign q_bit = trial >= {1'b0, cand_cap_r};

  // tie-break chain
  always_comb begin
    if (dvd_r != best_rel_r)                   beats = dvd_r < best_rel_r;
    else if (req_sync_r && cand_cur_r)         beats = 1'b1;
    else if (req_sync_r && best_cur_r)         beats = 1'b0;
    else if (cand_cap_r != best_cap_r)         beats = cand_cap_r > best_cap_r;
    else if (cand_lat_r != best_lat_r)         beats = cand_lat_r < best_lat_r;
    else if (cand_cpu_r == req_prev_cpu_r)     beats = 1'b1;
    else if (best_cpu_r == req_prev_cpu_r)     beats = 1'b0;
    else                                       beats = cand_cache_r && !best_cache_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_prev_cpu_r     <= '0;
      req_task_util_r    <= '0;
      req_sync_r         <= 1'b0;
      req_running_util_r <= '0;
      best_cpu_r         <= '0;
      best_rel_r         <= REL_SENTINEL;
      best_cap_r         <= '0;
      best_lat_r         <= LAT_SENTINEL;
      best_cache_r       <= 1'b0;
      best_cur_r         <= 1'b0;
      found_idle_r       <= 1'b0;
    end else if (cmd.start) begin
      req_prev_cpu_r     <= item.cpu_id;
      req_task_util_r    <= item.task_load;
      req_sync_r         <= item.sync;
      req_running_util_r <= item.cpu_util;
      best_cpu_r         <= item.cpu_id;
      best_rel_r         <= REL_SENTINEL;
      best_cap_r         <= '0;
      best_lat_r         <= LAT_SENTINEL;
      best_cache_r       <= 1'b0;
      best_cur_r         <= 1'b0;
      found_idle_r       <= 1'b0;
    end else if (cmd.update && beats) begin
      best_cpu_r   <= cand_cpu_r;
      best_rel_r   <= dvd_r;
      best_cap_r   <= cand_cap_r;
      best_lat_r   <= cand_lat_r;
      best_cache_r <= cand_cache_r;
      best_cur_r   <= cand_cur_r;
      if (cand_idle_r) found_idle_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cand_load) begin
      cand_cpu_r   <= item.cpu_id;
      cand_cap_r   <= cap_fix;
      cand_lat_r   <= lat_in;
      cand_cache_r <= item.shares_cache;
      cand_cur_r   <= item.is_current;
      cand_idle_r  <= cand_idle;
      dvd_r        <= {u_sum, CAP_SH'(0)};
      rem_r        <= '0;
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? CAP_W'(trial - {1'b0, cand_cap_r}) : trial[CAP_W-1:0];
      dvd_r <= {dvd_r[REL_W-2:0], q_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fast) begin
      sel_cpu_r  <= item.cpu_id;
      sel_fast_r <= 1'b1;
    end else if (cmd.finish) begin
      sel_cpu_r  <= best_cpu_r;
      sel_fast_r <= 1'b0;
    end
  end

  assign sel_cpu  = sel_cpu_r;
  assign sel_fast = sel_fast_r;

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import cacs_pkg::*;

  localparam int N_CPUS       = 64;
  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 5;
  localparam int DRAIN_CYCLES = 32;     // longer than a scored candidate keeps the block busy
  localparam int STALL_LIMIT  = 2000;   // cycles with no beat anywhere
  localparam int PHASE_BEATS  = 110;
  localparam int N_PHASES     = 4;

  // the one command code the block ignores
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // util_est_enable is register 0, paddr[2] selects the register
  localparam logic [CFG_ADDR_W-1:0] UTIL_EST_ADDR = {REG_UTIL_EST, 2'b00};

  typedef struct packed {
    logic [CPU_W-1:0] cpu;
    logic             fast;
  } pick_t;

  // one row of the directed table; the result is typed in only where obvious
  typedef struct packed {
    logic [1:0]       cmd;
    item_t            it;
    logic             typed;
    logic [CPU_W-1:0] cpu;
    logic             fast;
  } step_t;

  // ---------------------------------------------------------------------------
  // clock, reset and block inputs, all known from time zero
  // ---------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // item_t, cpu_id in the lowest bits
  logic [IN_USER_W-1:0]  in_tuser = '0;   // command[1:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // selected_cpu[5:0], zero[7:6]
  logic                  out_tuser;       // fast_path[0]
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // typed result travels along with its beat
  logic                  typed_valid = 1'b0;
  pick_t                 typed_pick = '0;

  // idling knobs, in percent of cycles
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  int mismatch_count = 0;
  int stall_count = 0;

  always #CLK_HALF clk = ~clk;

  capacity_aware_cpu_select #(
    .NUM_CPUS(N_CPUS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // ---------------------------------------------------------------------------
  // selection predictor: own copy of the search state and the register
  // ---------------------------------------------------------------------------
  logic              util_est_on = 1'b1;
  logic [CPU_W-1:0]  best_id = '0;
  logic [REL_W-1:0]  best_rel = REL_SENTINEL;
  logic [CAP_W-1:0]  best_cap = '0;
  logic [BLAT_W-1:0] best_lat = LAT_SENTINEL;
  logic              best_cache = 1'b0;
  logic              best_cur = 1'b0;
  logic              idle_winner = 1'b0;
  logic [CPU_W-1:0]  req_prev = '0;
  logic [UTIL_W-1:0] req_tutil = '0;
  logic              req_sync = 1'b0;
  logic [UTIL_W-1:0] req_run_util = '0;

  pick_t expected_picks[$];

  task automatic predict_selection(input logic [1:0] cmd, input item_t it,
                                   output bit has_pick, output pick_t pick);
    logic              cur_sync;
    logic              idle;
    logic              wins;
    logic [BLAT_W-1:0] lat;
    logic [SUM_W-1:0]  u;
    logic [CAP_W-1:0]  cap;
    logic [REL_W-1:0]  rel;
    has_pick = 1'b0;
    pick = '0;
    case (cmd)
      CMD_START: begin
        // open a request and seed the search with the previous processor
        req_prev     = it.cpu_id;
        req_tutil    = it.task_load;
        req_sync     = it.sync;
        req_run_util = it.cpu_util;
        best_id      = it.cpu_id;
        best_rel     = REL_SENTINEL;
        best_cap     = '0;
        best_lat     = LAT_SENTINEL;
        best_cache   = 1'b0;
        best_cur     = 1'b0;
        idle_winner  = 1'b0;
        if (it.cpu_idle) begin
          has_pick = 1'b1;
          pick = {it.cpu_id, 1'b1};
        end
      end
      CMD_CAND: begin
        // the waker on a sync wake counts as idle
        cur_sync = req_sync && it.is_current;
        idle = cur_sync || it.cpu_idle;
        if (int'(it.cpu_id) < N_CPUS && !(idle_winner && !idle)) begin
          lat = idle ? BLAT_W'(it.wake_lat) + 1'b1 : '0;
          u = SUM_W'(it.cpu_util);
          // on a sync wake the waker's load leaves with it
          if (cur_sync)
            u = (it.cpu_util > req_run_util) ? SUM_W'(it.cpu_util - req_run_util) : '0;
          if (util_est_on && SUM_W'(it.cpu_util_est) > u)
            u = SUM_W'(it.cpu_util_est);
          if (!it.is_task_cpu)
            u = u + SUM_W'(req_tutil);
          cap = (it.cpu_capacity == '0) ? CAP_W'(1) : it.cpu_capacity;
          rel = REL_W'((int'(u) * 1024) / int'(cap));
          // tie-break chain
          if (rel != best_rel)
            wins = rel < best_rel;
          else if (req_sync && it.is_current)
            wins = 1'b1;
          else if (req_sync && best_cur)
            wins = 1'b0;
          else if (cap != best_cap)
            wins = cap > best_cap;
          else if (lat != best_lat)
            wins = lat < best_lat;
          else if (it.cpu_id == req_prev)
            wins = 1'b1;
          else if (best_id == req_prev)
            wins = 1'b0;
          else
            wins = it.shares_cache > best_cache;
          if (wins) begin
            best_id    = it.cpu_id;
            best_rel   = rel;
            best_cap   = cap;
            best_lat   = lat;
            best_cache = it.shares_cache;
            best_cur   = it.is_current;
            if (idle)
              idle_winner = 1'b1;
          end
        end
      end
      CMD_FINISH: begin
        // the search stays open, a second finish repeats the answer
        has_pick = 1'b1;
        pick = {best_id, 1'b0};
      end
      default: begin
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // monitor: predicts on every input beat, checks every result beat,
  // and watches for a hang
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bit    has_pick;
    bit    moved;
    pick_t pick;
    pick_t want;
    if (rst_n) begin
      moved = 1'b0;
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        if (expected_picks.size() == 0) begin
          $error("result beat with nothing expected: selected_cpu %0d fast_path %0b",
                 out_tdata[CPU_W-1:0], out_tuser);
          mismatch_count++;
        end else begin
          want = expected_picks.pop_front();
          if (out_tdata[CPU_W-1:0] !== want.cpu) begin
            $error("selected_cpu: expected %0d, got %0d", want.cpu, out_tdata[CPU_W-1:0]);
            mismatch_count++;
          end
          if (out_tuser !== want.fast) begin
            $error("fast_path: expected %0b, got %0b", want.fast, out_tuser);
            mismatch_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        predict_selection(in_tuser, in_tdata, has_pick, pick);
        if (has_pick)
          expected_picks.push_back(typed_valid ? typed_pick : pick);
      end
      if (cfg_psel && cfg_penable)
        moved = 1'b1;
      stall_count = moved ? 0 : stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // receiver stalls at random
  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic item_t start_item(input int prev, input bit idle, input int run_util,
                                       input int tutil, input bit sync_wake);
    item_t it;
    it = '0;
    it.cpu_id    = CPU_W'(prev);
    it.cpu_idle  = idle;
    it.cpu_util  = UTIL_W'(run_util);
    it.task_load = UTIL_W'(tutil);
    it.sync      = sync_wake;
    return it;
  endfunction

  function automatic item_t cand_item(input int id, input bit idle, input int lat,
                                      input int util, input int est, input int cap,
                                      input bit cache, input bit cur, input bit own);
    item_t it;
    it = '0;
    it.cpu_id       = CPU_W'(id);
    it.cpu_idle     = idle;
    it.wake_lat     = LAT_W'(lat);
    it.cpu_util     = UTIL_W'(util);
    it.cpu_util_est = UTIL_W'(est);
    it.cpu_capacity = CAP_W'(cap);
    it.shares_cache = cache;
    it.is_current   = cur;
    it.is_task_cpu  = own;
    return it;
  endfunction

  // utilization drawn partly from a few common values so that scores tie often
  function automatic logic [UTIL_W-1:0] pooled_util();
    case ($urandom_range(3))
      0:       return '0;
      1:       return UTIL_W'(256 * $urandom_range(4));
      2:       return UTIL_W'($urandom_range(2047));
      default: return UTIL_W'($urandom_range(255));
    endcase
  endfunction

  function automatic item_t rand_item(input bit opening);
    item_t it;
    it = '0;
    it.cpu_id       = CPU_W'($urandom_range(63));
    // a start finds its previous processor idle now and then
    it.cpu_idle     = opening ? ($urandom_range(4) == 0) : 1'($urandom_range(1));
    it.wake_lat     = ($urandom_range(3) == 0) ? LAT_W'($urandom_range(65535))
                                               : LAT_W'($urandom_range(3));
    it.cpu_util     = pooled_util();
    it.cpu_util_est = pooled_util();
    case ($urandom_range(3))
      0:       it.cpu_capacity = CAP_W'(1024);
      1:       it.cpu_capacity = CAP_W'(512);
      2:       it.cpu_capacity = CAP_W'($urandom_range(1, 1024));
      default: it.cpu_capacity = CAP_W'($urandom_range(2047));
    endcase
    it.shares_cache = 1'($urandom_range(1));
    it.is_current   = 1'($urandom_range(1));
    it.is_task_cpu  = 1'($urandom_range(1));
    it.task_load    = ($urandom_range(7) == 0) ? UTIL_W'($urandom_range(2047))
                                               : UTIL_W'($urandom_range(1024));
    it.sync         = 1'($urandom_range(1));
    return it;
  endfunction

  // one input beat; valid stays up from beat to beat unless the sender idles
  task automatic send_beat(input logic [1:0] cmd, input item_t it,
                           input logic typed, input pick_t want);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tuser    <= cmd;
    in_tdata    <= it;
    typed_valid <= typed;
    typed_pick  <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // a well-formed request: start, a few candidates, finish
  task automatic send_request(output int beats);
    item_t            it;
    logic [CPU_W-1:0] prev;
    int               n;
    it = rand_item(1'b1);
    prev = it.cpu_id;
    send_beat(CMD_START, it, 1'b0, '0);
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      it = rand_item(1'b0);
      // the previous processor shows up as a candidate too
      if ($urandom_range(3) == 0)
        it.cpu_id = prev;
      send_beat(CMD_CAND, it, 1'b0, '0);
    end
    send_beat(CMD_FINISH, rand_item(1'b0), 1'b0, '0);
    beats = n + 2;
  endtask

  // let every expected result come out and the divider run dry
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // setup beat then access beat, only while the block is idle
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == UTIL_EST_ADDR)
      util_est_on = data[0];
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    step_t directed_steps[$];
    int    est_setting[N_PHASES];
    int    send_setting[N_PHASES];
    int    recv_setting[N_PHASES];
    int    sent;
    int    beats;
    logic [1:0] noise_cmd;

    est_setting  = '{0, 1, 0, 1};
    send_setting = '{0, 88, 0, 36};
    recv_setting = '{0, 0, 88, 36};

    directed_steps = '{
      // finish right after reset answers processor 0
      '{CMD_FINISH, '0, 1'b1, 6'd0, 1'b0},
      // candidate with no request open works on the reset state
      '{CMD_CAND, cand_item(12, 0, 0, 100, 0, 512, 0, 0, 0), 1'b0, 6'd0, 1'b0},
      '{CMD_FINISH, '0, 1'b0, 6'd0, 1'b0},
      // idle previous processor taken directly, a finish returns it again
      '{CMD_START, start_item(63, 1, 0, 0, 0), 1'b1, 6'd63, 1'b1},
      '{CMD_FINISH, '0, 1'b1, 6'd63, 1'b0},
      // sync wake, heaviest running load, task load 1024
      '{CMD_START, start_item(5, 0, 2047, 1024, 1), 1'b0, 6'd0, 1'b0},
      // zero capacity, top utilization
      '{CMD_CAND, cand_item(0, 0, 0, 2047, 2047, 0, 0, 0, 0), 1'b0, 6'd0, 1'b0},
      // the waker itself, longest exit latency
      '{CMD_CAND, cand_item(63, 1, 65535, 0, 0, 1024, 1, 1, 1), 1'b0, 6'd0, 1'b0},
      // busy candidate after an idle winner is skipped
      '{CMD_CAND, cand_item(10, 0, 0, 0, 0, 1024, 0, 0, 1), 1'b0, 6'd0, 1'b0},
      // same score, but the waker holds on a sync wake
      '{CMD_CAND, cand_item(11, 1, 0, 0, 0, 1024, 0, 0, 1), 1'b0, 6'd0, 1'b0},
      '{CMD_FINISH, '0, 1'b0, 6'd0, 1'b0},
      // unused command is dropped
      '{CMD_UNUSED, cand_item(1, 1, 7, 3, 3, 3, 1, 1, 1), 1'b0, 6'd0, 1'b0},
      // tie-break walk at equal relative utilization
      '{CMD_START, start_item(7, 0, 0, 0, 0), 1'b0, 6'd0, 1'b0},
      '{CMD_CAND, cand_item(1, 0, 0, 512, 0, 1024, 0, 0, 1), 1'b0, 6'd0, 1'b0},
      '{CMD_CAND, cand_item(2, 0, 0, 1024, 0, 2047, 0, 0, 1), 1'b0, 6'd0, 1'b0},
      '{CMD_CAND, cand_item(3, 1, 9, 1024, 0, 2047, 0, 0, 1), 1'b0, 6'd0, 1'b0},
      '{CMD_CAND, cand_item(7, 0, 0, 1024, 0, 2047, 0, 0, 1), 1'b0, 6'd0, 1'b0},
      '{CMD_CAND, cand_item(4, 0, 0, 1024, 0, 2047, 1, 0, 1), 1'b0, 6'd0, 1'b0},
      '{CMD_FINISH, '0, 1'b0, 6'd0, 1'b0},
      '{CMD_FINISH, '0, 1'b0, 6'd0, 1'b0},
      // sync wake where the waker's own load is taken off
      '{CMD_START, start_item(9, 0, 300, 200, 1), 1'b0, 6'd0, 1'b0},
      '{CMD_CAND, cand_item(20, 0, 0, 400, 600, 1024, 0, 1, 0), 1'b0, 6'd0, 1'b0},
      '{CMD_CAND, cand_item(21, 0, 0, 400, 0, 1024, 1, 0, 0), 1'b0, 6'd0, 1'b0},
      '{CMD_FINISH, '0, 1'b0, 6'd0, 1'b0}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed part runs at the reset setting of util_est_enable
    foreach (directed_steps[i])
      send_beat(directed_steps[i].cmd, directed_steps[i].it, directed_steps[i].typed,
                {directed_steps[i].cpu, directed_steps[i].fast});

    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      cfg_write(UTIL_EST_ADDR, CFG_DATA_W'(est_setting[p]));
      send_idle_pct = send_setting[p];
      recv_stall_pct = recv_setting[p];
      sent = 0;
      while (sent < PHASE_BEATS) begin
        if ($urandom_range(9) == 0) begin
          // stray beat: broken requests, repeated finishes, ignored commands
          noise_cmd = 2'($urandom_range(3));
          send_beat(noise_cmd, rand_item($urandom_range(1)), 1'b0, '0);
          if (noise_cmd != CMD_UNUSED)
            sent++;
        end else begin
          send_request(beats);
          sent += beats;
        end
      end
    end

    wait_drained();
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
